[rtl/http_request_line_parser_assert.svh]
// Assertion macros shared by the request-line parser RTL.
// Depends on nothing; each user supplies clk and rst in its own scope.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define HRLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that holds in the same cycle as the antecedent.
`define HRLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hrlp_pkg.sv]
// Shared widths, codes and beat types for the HTTP request-line parser.
// Depends on nothing; the other RTL files, apart from the assertion header, refer to it by scoped names.
package hrlp_pkg;

  // Field widths fixed by the external format.
  localparam int IDX_W  = 13;
  localparam int VER_W  = 10;
  localparam int BYTE_W = 8;

  // Default ring-buffer depth.
  localparam int BUF_DEPTH_DEF = 8192;

  // Status codes of a result beat.
  localparam logic [1:0] ST_MORE       = 2'd0;
  localparam logic [1:0] ST_DONE       = 2'd1;
  localparam logic [1:0] ST_BAD_METHOD = 2'd2;
  localparam logic [1:0] ST_BAD_REQ    = 2'd3;

  // Method codes.
  localparam logic [1:0] M_GET     = 2'd0;
  localparam logic [1:0] M_POST    = 2'd1;
  localparam logic [1:0] M_HEAD    = 2'd2;
  localparam logic [1:0] M_UNKNOWN = 2'd3;

  // One input byte after index reduction, handed from the input stage to the parser.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
  } beat_t;

endpackage

[rtl/hrlp_in_if.sv]
// Input channel of the request-line parser: one request byte and its buffer index.
// Depends on hrlp_pkg for the field widths.
interface hrlp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hrlp_pkg::BYTE_W-1:0]  data_byte;
  logic [hrlp_pkg::IDX_W-1:0]   byte_index;

  modport source (output valid, output data_byte, output byte_index, input ready);
  modport sink   (input valid, input data_byte, input byte_index, output ready);
endinterface

[rtl/hrlp_out_if.sv]
// Result channel of the request-line parser: status, method, versions and indices.
// Depends on hrlp_pkg for the field widths.
interface hrlp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [1:0]                  method_code;
  logic [hrlp_pkg::VER_W-1:0]  version_major;
  logic [hrlp_pkg::VER_W-1:0]  version_minor;
  logic [hrlp_pkg::IDX_W-1:0]  line_start_index;
  logic [hrlp_pkg::IDX_W-1:0]  method_end_index;
  logic [hrlp_pkg::IDX_W-1:0]  uri_start_index;
  logic [hrlp_pkg::IDX_W-1:0]  uri_end_index;
  logic [hrlp_pkg::IDX_W-1:0]  line_end_index;

  modport source (
    output valid, output status, output method_code, output version_major,
    output version_minor, output line_start_index, output method_end_index,
    output uri_start_index, output uri_end_index, output line_end_index,
    input ready
  );
  modport sink (
    input valid, input status, input method_code, input version_major,
    input version_minor, input line_start_index, input method_end_index,
    input uri_start_index, input uri_end_index, input line_end_index,
    output ready
  );
endinterface

[rtl/http_request_line_parser.sv]
// HTTP/1.x request-line parser: one request byte in, one result beat out.
// An accepted input beat passes the input register and then the result register to become its result beat.
// Throughput is one byte per cycle; the input register and the result register each
// stall only while the stage after them holds an untaken beat.
// Reset is synchronous: both stages empty, parser in the start phase, fields zero, method kind unknown.
// Depends on hrlp_pkg, hrlp_in_if, hrlp_out_if, hrlp_idx_reduce and hrlp_fsm.
module http_request_line_parser #(
  parameter int BUF_DEPTH = hrlp_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hrlp_in_if.sink     req,
  hrlp_out_if.source  res
);

  logic            beat_valid;
  logic            beat_ready;
  hrlp_pkg::beat_t beat;

  // Input register with index folding.
  hrlp_idx_reduce #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_idx_reduce (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  // State machine and result register.
  hrlp_fsm #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat),
    .res        (res)
  );

endmodule

[rtl/hrlp_idx_reduce.sv]
// Input register of the parser; folds the byte index into the ring-buffer range.
// Depends on hrlp_pkg and hrlp_in_if.
module hrlp_idx_reduce #(
  parameter int BUF_DEPTH = hrlp_pkg::BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hrlp_in_if.sink           req,
  output logic              beat_valid,
  input  logic              beat_ready,
  output hrlp_pkg::beat_t   beat
);

  localparam int IDX_W   = hrlp_pkg::IDX_W;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  logic [IDX_W-1:0] idx_red;
  logic             take;

  // Index modulo depth by restoring subtraction of the depth times each power of two
  // that still fits in the index range. Depths beyond the index range need no step.
  always_comb begin
    idx_red = req.byte_index;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((longint'(BUF_DEPTH) << k) <= longint'(IDX_MAX)) begin
        if (idx_red >= IDX_W'(longint'(BUF_DEPTH) << k)) begin
          idx_red = idx_red - IDX_W'(longint'(BUF_DEPTH) << k);
        end
      end
    end
  end

  // The register takes a new beat whenever it is empty or drains in this cycle.
  assign req.ready = !beat_valid || beat_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (req.ready) begin
      beat_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat.data_byte  <= req.data_byte;
      beat.byte_index <= idx_red;
    end
  end

endmodule

[rtl/hrlp_fsm.sv]
// Request-line state machine and result register of the parser.
// Depends on hrlp_pkg, hrlp_out_if and http_request_line_parser_assert.svh.
`include "http_request_line_parser_assert.svh"

module hrlp_fsm #(
  parameter int BUF_DEPTH = hrlp_pkg::BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat_valid,
  output logic              beat_ready,
  input  hrlp_pkg::beat_t   beat,
  hrlp_out_if.source        res
);

  localparam int IDX_W = hrlp_pkg::IDX_W;
  localparam int VER_W = hrlp_pkg::VER_W;

  // Parse phases; the unused code behaves like the start phase.
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_METHOD = 4'd1;
  localparam logic [3:0] PH_SP_URI = 4'd2;
  localparam logic [3:0] PH_URI    = 4'd3;
  localparam logic [3:0] PH_HTTP   = 4'd4;
  localparam logic [3:0] PH_H      = 4'd5;
  localparam logic [3:0] PH_HT     = 4'd6;
  localparam logic [3:0] PH_HTT    = 4'd7;
  localparam logic [3:0] PH_HTTP5  = 4'd8;
  localparam logic [3:0] PH_MAJ1   = 4'd9;
  localparam logic [3:0] PH_MAJ    = 4'd10;
  localparam logic [3:0] PH_MIN1   = 4'd11;
  localparam logic [3:0] PH_MIN    = 4'd12;
  localparam logic [3:0] PH_SP_END = 4'd13;
  localparam logic [3:0] PH_ALMOST = 4'd14;

  // Characters of the request line.
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [VER_W-1:0] VER_MAX = VER_W'(999);
  localparam logic [31:0] LET_GET  = 32'h0047_4554;
  localparam logic [31:0] LET_POST = 32'h504F_5354;
  localparam logic [31:0] LET_HEAD = 32'h4845_4144;

  // Upper-case letter or underscore.
  function automatic logic is_method_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // One more decimal digit, saturating at the version limit.
  function automatic logic [VER_W-1:0] ver_acc(input logic [VER_W-1:0] v,
                                               input logic [7:0] c);
    logic [13:0] n;
    n = 14'({v, 3'b000}) + 14'({v, 1'b0}) + 14'(c[3:0]);
    return (n > 14'(VER_MAX)) ? VER_MAX : n[VER_W-1:0];
  endfunction

  function automatic logic [1:0] classify(input logic [2:0] len, input logic [31:0] let3);
    logic [1:0] kind;
    kind = hrlp_pkg::M_UNKNOWN;
    if (len == 3'd3 && let3 == LET_GET) begin
      kind = hrlp_pkg::M_GET;
    end else if (len == 3'd4 && let3 == LET_POST) begin
      kind = hrlp_pkg::M_POST;
    end else if (len == 3'd4 && let3 == LET_HEAD) begin
      kind = hrlp_pkg::M_HEAD;
    end
    return kind;
  endfunction

  logic [3:0]       phase, phase_next;
  logic [2:0]       method_length, method_length_next;
  logic [31:0]      method_letters, method_letters_next;
  logic [1:0]       method_kind, method_kind_next;
  logic [VER_W-1:0] major_version, major_version_next;
  logic [VER_W-1:0] minor_version, minor_version_next;
  logic [IDX_W-1:0] start_index, start_index_next;
  logic [IDX_W-1:0] method_stop, method_stop_next;
  logic [IDX_W-1:0] uri_begin, uri_begin_next;
  logic [IDX_W-1:0] uri_stop, uri_stop_next;
  logic [IDX_W-1:0] end_index, end_index_next;
  logic             end_seen, end_seen_next;
  logic [1:0]       status_next;
  logic             done;
  logic             take;
  logic [7:0]       c;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] idx_dec;

  assign c   = beat.data_byte;
  assign idx = beat.byte_index;

  // Neighbors in the ring buffer, wrapping at the depth.
  assign idx_inc = (32'(idx) == BUF_DEPTH - 1) ? '0 : idx + 1'b1;
  assign idx_dec = (idx == '0) ? IDX_W'(BUF_DEPTH - 1) : idx - 1'b1;

  // A beat is parsed when the result register is free or drains now.
  assign beat_ready = !res.valid || res.ready;
  assign take       = beat_valid && beat_ready;

  // Next state for one request byte.
  always_comb begin
    phase_next          = phase;
    method_length_next  = method_length;
    method_letters_next = method_letters;
    method_kind_next    = method_kind;
    major_version_next  = major_version;
    minor_version_next  = minor_version;
    start_index_next    = start_index;
    method_stop_next    = method_stop;
    uri_begin_next      = uri_begin;
    uri_stop_next       = uri_stop;
    end_index_next      = end_index;
    end_seen_next       = end_seen;
    status_next         = hrlp_pkg::ST_MORE;
    done                = 1'b0;

    case (phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          method_stop_next = idx;
          method_kind_next = classify(method_length, method_letters);
          phase_next       = PH_SP_URI;
        end else if (is_method_char(c)) begin
          if (method_length < 3'd4) begin
            method_letters_next = {method_letters[23:0], c};
          end
          if (method_length < 3'd7) begin
            method_length_next = method_length + 3'd1;
          end
        end else begin
          status_next = hrlp_pkg::ST_BAD_METHOD;
        end
      end
      PH_SP_URI: begin
        if (c == CH_SLASH) begin
          uri_begin_next = idx_inc;
          phase_next     = PH_URI;
        end else if (c != CH_SP) begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_URI: begin
        if (c == CH_SP) begin
          uri_stop_next = idx;
          phase_next    = PH_HTTP;
        end
      end
      PH_HTTP: begin
        if (c == CH_H) begin
          phase_next = PH_H;
        end else if (c != CH_SP) begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_H: begin
        if (c == CH_T) phase_next = PH_HT; else status_next = hrlp_pkg::ST_BAD_REQ;
      end
      PH_HT: begin
        if (c == CH_T) phase_next = PH_HTT; else status_next = hrlp_pkg::ST_BAD_REQ;
      end
      PH_HTT: begin
        if (c == CH_P) phase_next = PH_HTTP5; else status_next = hrlp_pkg::ST_BAD_REQ;
      end
      PH_HTTP5: begin
        if (c == CH_SLASH) phase_next = PH_MAJ1; else status_next = hrlp_pkg::ST_BAD_REQ;
      end
      PH_MAJ1: begin
        if (c >= 8'h31 && c <= 8'h39) begin
          major_version_next = VER_W'(c[3:0]);
          phase_next         = PH_MAJ;
        end else begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_MAJ: begin
        if (c == CH_DOT) begin
          phase_next = PH_MIN1;
        end else if (is_digit(c)) begin
          major_version_next = ver_acc(major_version, c);
        end else begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_MIN1: begin
        if (is_digit(c)) begin
          minor_version_next = VER_W'(c[3:0]);
          phase_next         = PH_MIN;
        end else begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_MIN: begin
        if (c == CH_CR) begin
          phase_next = PH_ALMOST;
        end else if (c == CH_LF) begin
          done = 1'b1;
        end else if (c == CH_SP) begin
          phase_next = PH_SP_END;
        end else if (is_digit(c)) begin
          minor_version_next = ver_acc(minor_version, c);
        end else begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_SP_END: begin
        if (c == CH_CR) begin
          phase_next = PH_ALMOST;
        end else if (c == CH_LF) begin
          done = 1'b1;
        end else if (c != CH_SP) begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      PH_ALMOST: begin
        // The CR ending records the index of the CR itself.
        end_index_next = idx_dec;
        end_seen_next  = 1'b1;
        if (c == CH_LF) begin
          done = 1'b1;
        end else begin
          status_next = hrlp_pkg::ST_BAD_REQ;
        end
      end
      default: begin
        // Start phase: skip blank line bytes, reject a byte that cannot start a method, otherwise open a new method.
        start_index_next = idx;
        end_seen_next    = 1'b0;
        if (c == CH_CR || c == CH_LF) begin
          phase_next = PH_START;
        end else if (!is_method_char(c)) begin
          status_next = hrlp_pkg::ST_BAD_METHOD;
        end else begin
          method_length_next  = 3'd1;
          method_letters_next = {24'd0, c};
          phase_next          = PH_METHOD;
        end
      end
    endcase

    // End of line: a bare LF ending reports the LF index.
    if (done) begin
      if (!end_seen_next) begin
        end_index_next = idx;
      end
      status_next = hrlp_pkg::ST_DONE;
      phase_next  = PH_START;
    end
    if (status_next == hrlp_pkg::ST_BAD_METHOD || status_next == hrlp_pkg::ST_BAD_REQ) begin
      phase_next = PH_START;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      method_length  <= '0;
      method_letters <= '0;
      method_kind    <= hrlp_pkg::M_UNKNOWN;
      major_version  <= '0;
      minor_version  <= '0;
      start_index    <= '0;
      method_stop    <= '0;
      uri_begin      <= '0;
      uri_stop       <= '0;
      end_index      <= '0;
      end_seen       <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      method_length  <= method_length_next;
      method_letters <= method_letters_next;
      method_kind    <= method_kind_next;
      major_version  <= major_version_next;
      minor_version  <= minor_version_next;
      start_index    <= start_index_next;
      method_stop    <= method_stop_next;
      uri_begin      <= uri_begin_next;
      uri_stop       <= uri_stop_next;
      end_index      <= end_index_next;
      end_seen       <= end_seen_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (beat_ready) begin
      res.valid <= beat_valid;
    end
  end

  // Result payload: the status and every reported field after this byte.
  always_ff @(posedge clk) begin
    if (take) begin
      res.status           <= status_next;
      res.method_code      <= method_kind_next;
      res.version_major    <= major_version_next;
      res.version_minor    <= minor_version_next;
      res.line_start_index <= start_index_next;
      res.method_end_index <= method_stop_next;
      res.uri_start_index  <= uri_begin_next;
      res.uri_end_index    <= uri_stop_next;
      res.line_end_index   <= end_index_next;
    end
  end

  // Every parsed byte shows up as a result beat in the cycle after it is parsed.
  `HRLP_ASSERT_NEXT(a_take_gives_result, take, res.valid, "parsed byte produced no result")
  // A finished or rejected line always returns the parser to the start phase.
  `HRLP_ASSERT_NEXT(a_end_restarts, take && status_next != hrlp_pkg::ST_MORE,
                    phase == PH_START, "parser did not restart after line end")
  // Without a parsed byte the parser state does not move.
  `HRLP_ASSERT_NEXT(a_idle_holds, !take, $stable(phase) && $stable(method_length),
                    "parser state changed without a byte")
  // Reported versions never pass the saturation limit.
  `HRLP_ASSERT_SAME(a_ver_sat, res.valid,
                    res.version_major <= VER_MAX && res.version_minor <= VER_MAX,
                    "version above saturation limit")

endmodule
